/* rtl/core/pmq_pkg.sv */
// ----------------------------------------------------------------------------
// pmq_pkg
// Shared types and constants for the motion sensor level qualifier.
// ----------------------------------------------------------------------------
package pmq_pkg;

  localparam int TIME_WIDTH_DEF = 32;   // default internal timestamp width
  localparam int TS_W           = 32;   // timestamp fields on the ports
  localparam int CNT_W          = 32;   // event counter
  localparam int HOLD_W         = 16;
  localparam int CFG_DATA_W     = 32;
  localparam int CFG_IDX_W      = 1;

  localparam logic [TS_W-1:0]   WARMUP_RST = 32'd60000;
  localparam logic [HOLD_W-1:0] HOLD_RST   = 16'd50;

  // register indexes on the configuration port
  localparam logic [CFG_IDX_W-1:0] CFG_WARMUP_TIME = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_HOLD_TIME   = 1'b1;

  // input action codes
  localparam logic ACT_SAMPLE  = 1'b0;
  localparam logic ACT_RESTART = 1'b1;

  typedef struct packed {
    logic [TS_W-1:0]   warmup_time;
    logic [HOLD_W-1:0] hold_time;
  } cfg_t;

  typedef struct packed {
    logic ready;
    logic stable_level;
    logic cand_level;
    logic cand_counts;
  } flags_t;

  typedef struct packed {
    logic             ready_flag;
    logic             raw_echo;
    logic             motion_active;
    logic [CNT_W-1:0] event_total;
    logic [TS_W-1:0]  last_motion_time;
    logic [TS_W-1:0]  warmup_left;
  } res_t;

endpackage

/* rtl/core/pmq_cfg.sv */
// ----------------------------------------------------------------------------
// pmq_cfg
// Configuration registers: warm-up time and hold time.
// ----------------------------------------------------------------------------
module pmq_cfg (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             cfg_we,
  input  logic [pmq_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [pmq_pkg::CFG_DATA_W-1:0]   cfg_wdata,
  output pmq_pkg::cfg_t                    cfg
);
  import pmq_pkg::*;

  cfg_t cfg_r;
  cfg_t cfg_nxt;

  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_we) begin
      case (cfg_index)
        CFG_WARMUP_TIME: cfg_nxt.warmup_time = cfg_wdata[TS_W-1:0];
        CFG_HOLD_TIME:   cfg_nxt.hold_time   = cfg_wdata[HOLD_W-1:0];
        default:         cfg_nxt = cfg_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.warmup_time <= WARMUP_RST;
      cfg_r.hold_time   <= HOLD_RST;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  assign cfg = cfg_r;

endmodule

/* rtl/core/pmq_step.sv */
// ----------------------------------------------------------------------------
// pmq_step
// Next-state and snapshot logic for one transaction.
// ----------------------------------------------------------------------------
module pmq_step #(
  parameter int TIME_WIDTH = pmq_pkg::TIME_WIDTH_DEF
) (
  input  pmq_pkg::cfg_t                 cfg,
  input  logic                          act,
  input  logic [pmq_pkg::TS_W-1:0]      time_now,
  input  logic                          pin,
  input  pmq_pkg::flags_t               flags,
  input  logic [TIME_WIDTH-1:0]         start_time,
  input  logic [TIME_WIDTH-1:0]         cand_time,
  input  logic [TIME_WIDTH-1:0]         last_edge_time,
  input  logic [pmq_pkg::CNT_W-1:0]     edge_count,
  output pmq_pkg::flags_t               flags_nxt,
  output logic [TIME_WIDTH-1:0]         start_time_nxt,
  output logic [TIME_WIDTH-1:0]         cand_time_nxt,
  output logic [TIME_WIDTH-1:0]         last_edge_time_nxt,
  output logic [pmq_pkg::CNT_W-1:0]     edge_count_nxt,
  output pmq_pkg::res_t                 res
);
  import pmq_pkg::*;

  localparam int CW = (TIME_WIDTH > TS_W) ? TIME_WIDTH : TS_W;

  logic [CW-1:0]         now_ext;
  logic [TIME_WIDTH-1:0] now;
  logic                  cand_chg;
  logic                  cl, cc;
  logic [TIME_WIDTH-1:0] ct;
  logic [TIME_WIDTH-1:0] hold_el;
  logic [TIME_WIDTH-1:0] start_el;
  logic                  promote;
  logic                  rise;
  logic                  warm_done;
  logic [TIME_WIDTH-1:0] since;
  logic [CW-1:0]         since_ext;
  logic [CW-1:0]         last_ext;

  assign now_ext = CW'(time_now);
  assign now     = now_ext[TIME_WIDTH-1:0];

  // candidate tracking; timer restarts on every raw change
  assign cand_chg = pin != flags.cand_level;
  assign cl       = cand_chg ? pin : flags.cand_level;
  assign cc       = cand_chg ? flags.ready : flags.cand_counts;
  assign ct       = cand_chg ? now : cand_time;

  assign hold_el   = now - ct;
  assign start_el  = now - start_time;
  assign promote   = (cl != flags.stable_level) && (hold_el >= TIME_WIDTH'(cfg.hold_time));
  assign rise      = promote && cc && !flags.stable_level && cl;
  assign warm_done = CW'(start_el) >= CW'(cfg.warmup_time);

  always_comb begin
    if (act == ACT_RESTART) begin
      flags_nxt.ready        = 1'b0;
      flags_nxt.stable_level = pin;
      flags_nxt.cand_level   = pin;
      flags_nxt.cand_counts  = 1'b0;
      start_time_nxt         = now;
      cand_time_nxt          = now;
      edge_count_nxt         = '0;
      last_edge_time_nxt     = '0;
    end else begin
      flags_nxt.ready        = flags.ready || warm_done;
      flags_nxt.stable_level = promote ? cl : flags.stable_level;
      flags_nxt.cand_level   = cl;
      flags_nxt.cand_counts  = promote ? 1'b0 : cc;
      start_time_nxt         = start_time;
      cand_time_nxt          = ct;
      edge_count_nxt         = rise ? edge_count + CNT_W'(1) : edge_count;
      last_edge_time_nxt     = rise ? now : last_edge_time;
    end
  end

  assign since     = now - start_time_nxt;
  assign since_ext = CW'(since);
  assign last_ext  = CW'(last_edge_time_nxt);

  always_comb begin
    res.ready_flag       = flags_nxt.ready;
    res.raw_echo         = pin;
    res.motion_active    = flags_nxt.ready && flags_nxt.stable_level;
    res.event_total      = edge_count_nxt;
    res.last_motion_time = last_ext[TS_W-1:0];
    // below warmup_time, so the low bits carry the whole difference
    if (!flags_nxt.ready && (since_ext < CW'(cfg.warmup_time)))
      res.warmup_left = cfg.warmup_time - since_ext[TS_W-1:0];
    else
      res.warmup_left = '0;
  end

endmodule

/* rtl/core/pir_motion_qualifier_unit.sv */
// ----------------------------------------------------------------------------
// pir_motion_qualifier_unit
// Motion sensor level qualifier with hold-time filter and warm-up window.
// ----------------------------------------------------------------------------
// Takes one transaction per clock while the output side is not stalled and
// returns one snapshot per transaction. The transaction is captured in an
// input register, then the qualifier state (candidate, stable level,
// warm-up, event count) is updated by one pass of compare/subtract logic
// as it moves into the result register; that state update is combinational,
// which is what sets the one-per-clock rate. Timestamps are handled modulo
// 2^TIME_WIDTH; configuration must be written only while no transaction is in
// flight.
module pir_motion_qualifier_unit #(
  parameter int TIME_WIDTH = pmq_pkg::TIME_WIDTH_DEF
) (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             in_valid,
  output logic                             in_ready,
  input  logic                             in_action,
  input  logic [pmq_pkg::TS_W-1:0]         in_time_now,
  input  logic                             in_pin_level,
  output logic                             out_valid,
  input  logic                             out_ready,
  output logic                             out_ready_flag,
  output logic                             out_raw_echo,
  output logic                             out_motion_active,
  output logic [pmq_pkg::CNT_W-1:0]        out_event_total,
  output logic [pmq_pkg::TS_W-1:0]         out_last_motion_time,
  output logic [pmq_pkg::TS_W-1:0]         out_warmup_left,
  input  logic                             cfg_we,
  input  logic [pmq_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [pmq_pkg::CFG_DATA_W-1:0]   cfg_wdata
);
  import pmq_pkg::*;

  cfg_t cfg;

  // input register
  logic             in_vld_r;
  logic             in_act_r;
  logic [TS_W-1:0]  in_time_r;
  logic             in_pin_r;

  // qualifier state
  flags_t                flags_r, flags_nxt;
  logic [TIME_WIDTH-1:0] start_time_r, start_time_nxt;
  logic [TIME_WIDTH-1:0] cand_time_r, cand_time_nxt;
  logic [TIME_WIDTH-1:0] last_edge_r, last_edge_nxt;
  logic [CNT_W-1:0]      edge_cnt_r, edge_cnt_nxt;

  // result register
  logic out_vld_r;
  res_t res_nxt;
  res_t res_r;

  logic in_acc;
  logic adv;

  assign adv      = in_vld_r && (!out_vld_r || out_ready);
  assign in_ready = !in_vld_r || adv;
  assign in_acc   = in_valid && in_ready;

  pmq_cfg u_cfg (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .cfg       (cfg)
  );

  pmq_step #(
    .TIME_WIDTH (TIME_WIDTH)
  ) u_step (
    .cfg                (cfg),
    .act                (in_act_r),
    .time_now           (in_time_r),
    .pin                (in_pin_r),
    .flags              (flags_r),
    .start_time         (start_time_r),
    .cand_time          (cand_time_r),
    .last_edge_time     (last_edge_r),
    .edge_count         (edge_cnt_r),
    .flags_nxt          (flags_nxt),
    .start_time_nxt     (start_time_nxt),
    .cand_time_nxt      (cand_time_nxt),
    .last_edge_time_nxt (last_edge_nxt),
    .edge_count_nxt     (edge_cnt_nxt),
    .res                (res_nxt)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_vld_r <= 1'b0;
    end else if (in_acc) begin
      in_vld_r <= 1'b1;
    end else if (adv) begin
      in_vld_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      in_act_r  <= in_action;
      in_time_r <= in_time_now;
      in_pin_r  <= in_pin_level;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      flags_r      <= '0;
      start_time_r <= '0;
      cand_time_r  <= '0;
      last_edge_r  <= '0;
      edge_cnt_r   <= '0;
    end else if (adv) begin
      flags_r      <= flags_nxt;
      start_time_r <= start_time_nxt;
      cand_time_r  <= cand_time_nxt;
      last_edge_r  <= last_edge_nxt;
      edge_cnt_r   <= edge_cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_vld_r <= 1'b0;
    end else if (adv) begin
      out_vld_r <= 1'b1;
    end else if (out_ready) begin
      out_vld_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      res_r <= res_nxt;
    end
  end

  assign out_valid            = out_vld_r;
  assign out_ready_flag       = res_r.ready_flag;
  assign out_raw_echo         = res_r.raw_echo;
  assign out_motion_active    = res_r.motion_active;
  assign out_event_total      = res_r.event_total;
  assign out_last_motion_time = res_r.last_motion_time;
  assign out_warmup_left      = res_r.warmup_left;

  // restart snapshot reports warming up with cleared count
  a_restart_snap: assert property (@(posedge clk) disable iff (!rst_n)
    (adv && in_act_r == ACT_RESTART) |=>
      (!out_ready_flag && !out_motion_active && out_event_total == '0 &&
       out_last_motion_time == '0))
    else $error("restart snapshot not cleared");

  // once ready, no warm-up remains
  a_ready_left: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_ready_flag) |-> (out_warmup_left == '0))
    else $error("warm-up left while ready");

  // a sample adds at most one event
  a_count_step: assert property (@(posedge clk) disable iff (!rst_n)
    (adv && in_act_r == ACT_SAMPLE) |=>
      (out_event_total == $past(edge_cnt_r) ||
       out_event_total == $past(edge_cnt_r) + CNT_W'(1)))
    else $error("event count jumped");

  // ready stays set until the next restart
  a_ready_sticky: assert property (@(posedge clk) disable iff (!rst_n)
    (adv && in_act_r == ACT_SAMPLE && flags_r.ready) |=> out_ready_flag)
    else $error("ready dropped without restart");

endmodule

/* sim/pir_motion_qualifier_unit_tb.sv */
// ----------------------------------------------------------------------------
// pir_motion_qualifier_unit_tb
// Self-checking bench for the motion sensor level qualifier. A scoreboard
// keeps its own copy of the filter, warm-up and edge-count state and predicts
// one snapshot per accepted transaction. Snapshots are compared field by
// field, in order. Directed corner cases come first. Random phases follow
// under several filter settings and idle patterns, and one long output
// stall backs up the input side.
// ----------------------------------------------------------------------------
module pir_motion_qualifier_unit_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import pmq_pkg::*;

  class motion_scoreboard;
    logic [TS_W-1:0]   warmup_ms;
    logic [HOLD_W-1:0] hold_ms;
    logic              is_ready;
    logic              raw_lvl;
    logic              stable_lvl;
    logic              cand_lvl;
    logic              cand_counts;
    logic [TS_W-1:0]   start_ts;
    logic [TS_W-1:0]   cand_ts;
    logic [CNT_W-1:0]  edge_total;
    logic [TS_W-1:0]   last_edge_ts;
    res_t              snap_q[$];
    int                errors;

    function new();
      warmup_ms    = WARMUP_RST;
      hold_ms      = HOLD_RST;
      is_ready     = 1'b0;
      raw_lvl      = 1'b0;
      stable_lvl   = 1'b0;
      cand_lvl     = 1'b0;
      cand_counts  = 1'b0;
      start_ts     = '0;
      cand_ts      = '0;
      edge_total   = '0;
      last_edge_ts = '0;
      errors       = 0;
    endfunction

    function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
      case (idx)
        CFG_WARMUP_TIME: warmup_ms = val;
        CFG_HOLD_TIME:   hold_ms = val[HOLD_W-1:0];
        default: ;
      endcase
    endfunction

    // advance the filter by one accepted transaction and queue its snapshot
    function void note_sample(logic act, logic [TS_W-1:0] now, logic pin);
      logic [TS_W-1:0] since;
      logic [TS_W-1:0] held;
      logic            was_high;
      res_t            snap;
      raw_lvl = pin;
      if (act == ACT_RESTART) begin
        stable_lvl   = pin;
        cand_lvl     = pin;
        cand_counts  = 1'b0;
        is_ready     = 1'b0;
        start_ts     = now;
        cand_ts      = now;
        edge_total   = '0;
        last_edge_ts = '0;
      end else begin
        if (raw_lvl != cand_lvl) begin
          cand_lvl    = raw_lvl;
          cand_counts = is_ready;
          cand_ts     = now;
        end
        held = now - cand_ts;
        if (cand_lvl != stable_lvl && held >= {16'b0, hold_ms}) begin
          was_high   = stable_lvl;
          stable_lvl = cand_lvl;
          // only a change that began after warm-up counts
          if (cand_counts && !was_high && stable_lvl) begin
            edge_total   = edge_total + 1'b1;
            last_edge_ts = now;
          end
          cand_counts = 1'b0;
        end
        if (!is_ready && (now - start_ts) >= warmup_ms)
          is_ready = 1'b1;
      end
      since                 = now - start_ts;
      snap.ready_flag       = is_ready;
      snap.raw_echo         = raw_lvl;
      snap.motion_active    = is_ready && stable_lvl;
      snap.event_total      = edge_total;
      snap.last_motion_time = last_edge_ts;
      snap.warmup_left      = (!is_ready && since < warmup_ms) ? warmup_ms - since : '0;
      snap_q.push_back(snap);
    endfunction

    function int pending();
      return snap_q.size();
    endfunction

    function void report(string field, logic [31:0] want, logic [31:0] got);
      $display("%0t ns: %s mismatch, expected %0h, got %0h", $time, field, want, got);
      errors++;
    endfunction

    function void check_snapshot(res_t got);
      res_t want;
      if (snap_q.size() == 0) begin
        $display("%0t ns: snapshot with no transaction outstanding", $time);
        errors++;
        return;
      end
      want = snap_q.pop_front();
      if (got.ready_flag !== want.ready_flag)
        report("ready_flag", want.ready_flag, got.ready_flag);
      if (got.raw_echo !== want.raw_echo)
        report("raw_echo", want.raw_echo, got.raw_echo);
      if (got.motion_active !== want.motion_active)
        report("motion_active", want.motion_active, got.motion_active);
      if (got.event_total !== want.event_total)
        report("event_total", want.event_total, got.event_total);
      if (got.last_motion_time !== want.last_motion_time)
        report("last_motion_time", want.last_motion_time, got.last_motion_time);
      if (got.warmup_left !== want.warmup_left)
        report("warmup_left", want.warmup_left, got.warmup_left);
    endfunction
  endclass

  logic                  clk;
  logic                  rst_n;
  logic                  in_valid;
  logic                  in_ready;
  logic                  in_action;
  logic [TS_W-1:0]       in_time_now;
  logic                  in_pin_level;
  logic                  out_valid;
  logic                  out_ready;
  logic                  out_ready_flag;
  logic                  out_raw_echo;
  logic                  out_motion_active;
  logic [CNT_W-1:0]      out_event_total;
  logic [TS_W-1:0]       out_last_motion_time;
  logic [TS_W-1:0]       out_warmup_left;
  logic                  cfg_we;
  logic [CFG_IDX_W-1:0]  cfg_index;
  logic [CFG_DATA_W-1:0] cfg_wdata;

  motion_scoreboard sb;
  int               src_idle;
  int               dst_idle;
  bit               stall_req;
  logic [TS_W-1:0]  cur_ts;
  res_t             seen;

  pir_motion_qualifier_unit dut (
    .clk                  (clk),
    .rst_n                (rst_n),
    .in_valid             (in_valid),
    .in_ready             (in_ready),
    .in_action            (in_action),
    .in_time_now          (in_time_now),
    .in_pin_level         (in_pin_level),
    .out_valid            (out_valid),
    .out_ready            (out_ready),
    .out_ready_flag       (out_ready_flag),
    .out_raw_echo         (out_raw_echo),
    .out_motion_active    (out_motion_active),
    .out_event_total      (out_event_total),
    .out_last_motion_time (out_last_motion_time),
    .out_warmup_left      (out_warmup_left),
    .cfg_we               (cfg_we),
    .cfg_index            (cfg_index),
    .cfg_wdata            (cfg_wdata)
  );

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  initial begin
    #5_000_000;
    $display("pir_motion_qualifier_unit_tb: FAIL");
    $finish;
  end

  // receiver: random back-pressure, plus one long hold-off on request
  initial begin
    out_ready = 1'b0;
    forever begin
      @(negedge clk);
      if (stall_req) begin
        out_ready <= 1'b0;
        repeat (300) @(negedge clk);
        stall_req = 1'b0;
      end
      out_ready <= ($urandom_range(0, 99) >= dst_idle);
    end
  end

  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready) begin
      seen.ready_flag       = out_ready_flag;
      seen.raw_echo         = out_raw_echo;
      seen.motion_active    = out_motion_active;
      seen.event_total      = out_event_total;
      seen.last_motion_time = out_last_motion_time;
      seen.warmup_left      = out_warmup_left;
      sb.check_snapshot(seen);
    end
  end

  // called at a falling edge; returns at the falling edge after acceptance
  task automatic send_item(input logic act, input logic [TS_W-1:0] ts, input logic pin);
    while ($urandom_range(0, 99) < src_idle) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid     <= 1'b1;
    in_action    <= act;
    in_time_now  <= ts;
    in_pin_level <= pin;
    do @(posedge clk); while (!in_ready);
    sb.note_sample(act, ts, pin);
    @(negedge clk);
  endtask

  // both registers, written back to back once the pipeline has drained
  task automatic configure(input logic [TS_W-1:0] warm, input logic [HOLD_W-1:0] hold);
    in_valid <= 1'b0;
    while (sb.pending() != 0) @(negedge clk);
    repeat (4) @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= CFG_WARMUP_TIME;
    cfg_wdata <= warm;
    sb.write_reg(CFG_WARMUP_TIME, warm);
    @(negedge clk);
    cfg_index <= CFG_HOLD_TIME;
    cfg_wdata <= {16'b0, hold};
    sb.write_reg(CFG_HOLD_TIME, {16'b0, hold});
    @(negedge clk);
    cfg_we <= 1'b0;
    @(negedge clk);
  endtask

  task automatic run_phase(input int n_items, input bit with_stall);
    logic [TS_W-1:0]   warm;
    logic [HOLD_W-1:0] hold;
    logic              pin;
    int                span;
    int                r;
    case ($urandom_range(0, 9))
      0: warm = '0;
      1: warm = '1;
      2: warm = $urandom;
      default: warm = $urandom_range(0, 400);
    endcase
    case ($urandom_range(0, 9))
      0: hold = '0;
      1: hold = '1;
      2: hold = 16'($urandom_range(0, 16'hFFFF));
      default: hold = 16'($urandom_range(0, 60));
    endcase
    configure(warm, hold);
    // hold the receiver off while the sender keeps offering transactions
    if (with_stall)
      stall_req = 1'b1;
    span = hold / 2 + 8;
    pin  = 1'($urandom_range(0, 1));
    cur_ts = $urandom;
    send_item(ACT_RESTART, cur_ts, pin);
    for (int i = 1; i < n_items; i++) begin
      r = $urandom_range(0, 99);
      if (r < 4) begin
        cur_ts = cur_ts + $urandom_range(0, span);
        pin    = 1'($urandom_range(0, 1));
        send_item(ACT_RESTART, cur_ts, pin);
      end else if (r < 12) begin
        // noise: arbitrary timestamp jump and action
        cur_ts = $urandom;
        pin    = 1'($urandom_range(0, 1));
        send_item(1'($urandom_range(0, 1)), cur_ts, pin);
      end else begin
        if (r < 15)
          cur_ts = cur_ts + $urandom;
        else
          cur_ts = cur_ts + $urandom_range(0, span);
        if ($urandom_range(0, 99) < 25)
          pin = ~pin;
        send_item(ACT_SAMPLE, cur_ts, pin);
      end
    end
  endtask

  initial begin
    sb           = new();
    src_idle     = 34;
    dst_idle     = 66;
    stall_req    = 1'b0;
    rst_n        = 1'b0;
    in_valid     = 1'b0;
    in_action    = ACT_SAMPLE;
    in_time_now  = '0;
    in_pin_level = 1'b0;
    cfg_we       = 1'b0;
    cfg_index    = CFG_WARMUP_TIME;
    cfg_wdata    = '0;
    repeat (11) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // reset settings, starting without a restart
    send_item(ACT_SAMPLE,  32'd0,     1'b0);
    send_item(ACT_SAMPLE,  32'd20,    1'b1);
    send_item(ACT_SAMPLE,  32'd70,    1'b1);
    send_item(ACT_SAMPLE,  32'd60000, 1'b1);
    send_item(ACT_SAMPLE,  32'd60010, 1'b0);
    send_item(ACT_SAMPLE,  32'd60100, 1'b0);
    send_item(ACT_SAMPLE,  32'd60150, 1'b1);
    send_item(ACT_SAMPLE,  32'd60200, 1'b1);
    send_item(ACT_RESTART, 32'd70000, 1'b1);

    // no warm-up, no hold, timestamps across the wrap
    configure('0, '0);
    send_item(ACT_RESTART, 32'hFFFF_FFF0, 1'b0);
    send_item(ACT_SAMPLE,  32'hFFFF_FFF0, 1'b1);
    send_item(ACT_SAMPLE,  32'hFFFF_FFF8, 1'b0);
    send_item(ACT_SAMPLE,  32'h0000_0004, 1'b1);
    send_item(ACT_SAMPLE,  32'h0000_000A, 1'b0);

    // widest settings
    configure('1, '1);
    send_item(ACT_RESTART, 32'h0000_0005, 1'b0);
    send_item(ACT_SAMPLE,  32'h0001_0004, 1'b1);
    send_item(ACT_SAMPLE,  32'h0002_0003, 1'b1);
    send_item(ACT_SAMPLE,  32'hFFFF_FFFF, 1'b1);
    send_item(ACT_SAMPLE,  32'h0000_0004, 1'b1);
    send_item(ACT_SAMPLE,  32'h0000_0005, 1'b0);
    send_item(ACT_RESTART, 32'hFFFF_FFFF, 1'b1);

    run_phase(150, 1'b0);
    run_phase(150, 1'b1);
    src_idle = 66;
    dst_idle = 34;
    run_phase(150, 1'b0);
    run_phase(150, 1'b0);
    src_idle = 0;
    dst_idle = 0;
    run_phase(150, 1'b0);
    run_phase(150, 1'b0);

    in_valid <= 1'b0;
    while (sb.pending() != 0) @(negedge clk);
    repeat (10) @(negedge clk);
    if (sb.errors == 0 && sb.pending() == 0) begin
      $display("pir_motion_qualifier_unit_tb: PASS");
    end else begin
      $display("pir_motion_qualifier_unit_tb: FAIL");
    end
    $finish;
  end

endmodule
